### hw/rtl/idm_pkg.sv
// ----------------------------------------------------------------------------
// idm_pkg: shared constants for the inverted dropout masker
// Register indexes, generator constants and default widths.
// ----------------------------------------------------------------------------
package idm_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 16;
    localparam int COUNT_WIDTH_DEFAULT = 32;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 64;
    localparam int GEN_WIDTH       = 64;
    localparam int THRESH_WIDTH    = 16;
    localparam int SCALE_WIDTH     = 16;
    localparam int SCALE_FRAC      = 12;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TRAINING  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCALE     = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SEED      = 2'd3;

    localparam logic                    OP_FORWARD  = 1'b0;
    localparam logic                    OP_BACKWARD = 1'b1;

    localparam logic [GEN_WIDTH-1:0]    DEFAULT_SEED  = 64'h0000_0005_DEEC_E66D;
    localparam logic [SCALE_WIDTH-1:0]  SCALE_RESET   = 16'd4096;
    localparam int                      XS_SHIFT_A    = 13;
    localparam int                      XS_SHIFT_B    = 7;
    localparam int                      XS_SHIFT_C    = 17;

    // One step of the 64-bit xorshift generator.
    function automatic logic [GEN_WIDTH-1:0] xorshift_step(input logic [GEN_WIDTH-1:0] x);
        logic [GEN_WIDTH-1:0] t;
        begin
            t = x ^ (x << XS_SHIFT_A);
            t = t ^ (t >> XS_SHIFT_B);
            t = t ^ (t << XS_SHIFT_C);
            return t;
        end
    endfunction

endpackage

### hw/rtl/inverted_dropout_masker_top.sv
// ----------------------------------------------------------------------------
// inverted_dropout_masker_top: streaming inverted dropout with xorshift mask
// Forward items draw a keep/drop decision from a 64-bit xorshift generator,
// backward items apply a supplied mask; in training, kept values are scaled by Q4.12.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                                | tuser | tlast
//  s_*     | in  | value_in, mask_in                                 | op    | vector_end
//  m_*     | out | value_out, keep_flag, dropped_total, seen_total   | -     | vector_end_out
//  cfg_*   | in  | write-only registers, index 0..3                  |       |
//
//  One transaction accepted per cycle unless m_tready stalls; the result passes
//  the decision register, then the result register. Forward items in training
//  update generator and counters in the accept cycle with a single xorshift
//  step and a saturating increment; a config write blocks the generator step.
//  Reset: training on, threshold 0, scale 4096, generator 0x5DEECE66D,
//  counters zero.
//  A stall on m_tready holds the result register; an empty decision register
//  still takes one item, then s_tready drops until m_tready returns.
// ----------------------------------------------------------------------------
module inverted_dropout_masker_top #(
    parameter int VALUE_WIDTH = idm_pkg::VALUE_WIDTH_DEFAULT,
    parameter int COUNT_WIDTH = idm_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // value_in, mask_in
    input  logic [((VALUE_WIDTH+1+7)/8)*8-1:0]      s_tdata,
    // op
    input  logic                                    s_tuser,
    input  logic                                    s_tlast,

    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // value_out, keep_flag, dropped_total, seen_total
    output logic [((VALUE_WIDTH+1+2*COUNT_WIDTH+7)/8)*8-1:0] m_tdata,
    output logic                                    m_tlast,

    input  logic                                    cfg_wr_en,
    input  logic [idm_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [idm_pkg::CFG_DATA_WIDTH-1:0]      cfg_wdata
);

    localparam int OUT_TDATA_W = ((VALUE_WIDTH + 1 + 2*COUNT_WIDTH + 7) / 8) * 8;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // configuration
    logic                               training_reg;
    logic [idm_pkg::THRESH_WIDTH-1:0]   threshold_reg;
    logic [idm_pkg::SCALE_WIDTH-1:0]    scale_reg;
    logic [idm_pkg::GEN_WIDTH-1:0]      gen_reg;
    logic [idm_pkg::GEN_WIDTH-1:0]      gen_next;
    logic [COUNT_WIDTH-1:0]             dropped_reg;
    logic [COUNT_WIDTH-1:0]             dropped_next;
    logic [COUNT_WIDTH-1:0]             seen_reg;
    logic [COUNT_WIDTH-1:0]             seen_next;

    // decision stage
    logic                               s1_valid_reg;
    logic                               s1_op_reg;
    logic                               s1_training_reg;
    logic                               s1_drop_reg;
    logic                               s1_mask_reg;
    logic                               s1_last_reg;
    logic signed [VALUE_WIDTH-1:0]      s1_value_reg;
    logic [COUNT_WIDTH-1:0]             s1_dropped_reg;
    logic [COUNT_WIDTH-1:0]             s1_seen_reg;

    // result stage
    logic                               out_valid_reg;
    logic signed [VALUE_WIDTH-1:0]      out_value_reg;
    logic                               out_keep_reg;
    logic                               out_last_reg;
    logic [COUNT_WIDTH-1:0]             out_dropped_reg;
    logic [COUNT_WIDTH-1:0]             out_seen_reg;

    logic                               in_fire;
    logic                               out_load;
    logic                               is_forward;
    logic                               drop;
    logic signed [VALUE_WIDTH-1:0]      in_value;
    logic signed [VALUE_WIDTH-1:0]      scaled;
    logic signed [VALUE_WIDTH-1:0]      result_value;
    logic                               result_keep;

    assign out_load   = !out_valid_reg || m_tready;
    assign s_tready   = !s1_valid_reg || out_load;
    assign in_fire    = s_tvalid && s_tready;
    assign in_value   = s_tdata[VALUE_WIDTH-1:0];
    assign is_forward = (s_tuser == idm_pkg::OP_FORWARD);

    always_comb
    begin
        gen_next     = idm_pkg::xorshift_step(gen_reg);
        drop         = (gen_next[idm_pkg::GEN_WIDTH-1 -: idm_pkg::THRESH_WIDTH] < threshold_reg);
        seen_next    = seen_reg;
        dropped_next = dropped_reg;
        if (is_forward && training_reg)
        begin
            seen_next = (seen_reg == COUNT_MAX) ? seen_reg : seen_reg + 1'b1;
            if (drop)
            begin
                dropped_next = (dropped_reg == COUNT_MAX) ? dropped_reg : dropped_reg + 1'b1;
            end
        end
    end

    // configuration registers, generator and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            training_reg  <= 1'b1;
            threshold_reg <= '0;
            scale_reg     <= idm_pkg::SCALE_RESET;
            gen_reg       <= idm_pkg::DEFAULT_SEED;
            dropped_reg   <= '0;
            seen_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    idm_pkg::REG_TRAINING:  training_reg  <= cfg_wdata[0];
                    idm_pkg::REG_THRESHOLD: threshold_reg <= cfg_wdata[idm_pkg::THRESH_WIDTH-1:0];
                    idm_pkg::REG_SCALE:     scale_reg     <= cfg_wdata[idm_pkg::SCALE_WIDTH-1:0];
                    idm_pkg::REG_SEED:
                    begin
                        gen_reg <= (cfg_wdata != '0) ? cfg_wdata : idm_pkg::DEFAULT_SEED;
                    end
                    default: ;
                endcase
            end
            else if (in_fire && is_forward && training_reg)
            begin
                gen_reg <= gen_next;
            end
            if (in_fire)
            begin
                seen_reg    <= seen_next;
                dropped_reg <= dropped_next;
            end
        end
    end

    // decision stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg       <= s_tuser;
            s1_training_reg <= training_reg;
            s1_drop_reg     <= drop;
            s1_mask_reg     <= s_tdata[VALUE_WIDTH];
            s1_last_reg     <= s_tlast;
            s1_value_reg    <= in_value;
            s1_dropped_reg  <= dropped_next;
            s1_seen_reg     <= seen_next;
        end
    end

    idm_scaler #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_scaler (
        .value  (s1_value_reg),
        .scale  (scale_reg),
        .scaled (scaled)
    );

    always_comb
    begin
        result_value = s1_value_reg;
        result_keep  = 1'b0;
        if (!s1_training_reg)
        begin
            result_keep = (s1_op_reg == idm_pkg::OP_FORWARD);
        end
        else if (s1_op_reg == idm_pkg::OP_FORWARD)
        begin
            result_value = s1_drop_reg ? '0 : scaled;
            result_keep  = !s1_drop_reg;
        end
        else
        begin
            result_value = s1_mask_reg ? scaled : '0;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg)
        begin
            out_value_reg   <= result_value;
            out_keep_reg    <= result_keep;
            out_last_reg    <= s1_last_reg;
            out_dropped_reg <= s1_dropped_reg;
            out_seen_reg    <= s1_seen_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_TDATA_W'({out_seen_reg, out_dropped_reg, out_keep_reg, out_value_reg});

    // generator never reaches the all-zero lockup state
    assert property (@(posedge clk) disable iff (!rst_n) gen_reg != '0)
        else $error("generator state is zero");

    // drops are a subset of seen forward items
    assert property (@(posedge clk) disable iff (!rst_n) dropped_reg <= seen_reg)
        else $error("drop count exceeds element count");

    // a dropped forward transaction bumps the drop counter unless saturated
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_forward && training_reg && drop && dropped_reg != COUNT_MAX)
        |=> dropped_reg == $past(dropped_reg) + 1'b1)
        else $error("drop counter missed a dropped element");

    // backward items leave the generator untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !is_forward && !cfg_wr_en) |=> $stable(gen_reg))
        else $error("generator moved on a backward item");

endmodule

### hw/rtl/idm_scaler.sv
// ----------------------------------------------------------------------------
// idm_scaler: Q4.12 gain with floor and saturation
// Multiplies a signed value by an unsigned Q4.12 scale, shifts right with
// floor and clamps the result to the value width.
// ----------------------------------------------------------------------------
module idm_scaler #(
    parameter int VALUE_WIDTH = idm_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic signed [VALUE_WIDTH-1:0]           value,
    input  logic        [idm_pkg::SCALE_WIDTH-1:0]  scale,
    output logic signed [VALUE_WIDTH-1:0]           scaled
);

    localparam int PW = VALUE_WIDTH + idm_pkg::SCALE_WIDTH + 1;

    localparam logic signed [PW-1:0] MAX_VAL =
        {{(PW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [PW-1:0] MIN_VAL = ~MAX_VAL;

    logic signed [PW-1:0] product;
    logic signed [PW-1:0] shifted;

    always_comb
    begin
        product = PW'(value) * $signed({1'b0, scale});
        // arithmetic shift gives floor toward minus infinity
        shifted = product >>> idm_pkg::SCALE_FRAC;
        if (shifted > MAX_VAL)
        begin
            scaled = MAX_VAL[VALUE_WIDTH-1:0];
        end
        else if (shifted < MIN_VAL)
        begin
            scaled = MIN_VAL[VALUE_WIDTH-1:0];
        end
        else
        begin
            scaled = shifted[VALUE_WIDTH-1:0];
        end
    end

endmodule

### verif/inverted_dropout_masker_checker.sv
// ----------------------------------------------------------------------------
// inverted_dropout_masker_checker: result predictor and comparator
// Watches the input, output and register-write ports of the dropout masker.
// It keeps its own generator, counters and register copies, predicts each
// output transaction and compares it field by field, in order.
// ----------------------------------------------------------------------------
module inverted_dropout_masker_checker #(
    parameter int VALUE_WIDTH = idm_pkg::VALUE_WIDTH_DEFAULT,
    parameter int COUNT_WIDTH = idm_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             s_tvalid,
    input  logic                                             s_tready,
    // value_in, mask_in
    input  logic [((VALUE_WIDTH+1+7)/8)*8-1:0]               s_tdata,
    // op
    input  logic                                             s_tuser,
    input  logic                                             s_tlast,
    input  logic                                             m_tvalid,
    input  logic                                             m_tready,
    // value_out, keep_flag, dropped_total, seen_total
    input  logic [((VALUE_WIDTH+1+2*COUNT_WIDTH+7)/8)*8-1:0] m_tdata,
    input  logic                                             m_tlast,
    input  logic                                             cfg_wr_en,
    input  logic [idm_pkg::CFG_INDEX_WIDTH-1:0]              cfg_index,
    input  logic [idm_pkg::CFG_DATA_WIDTH-1:0]               cfg_wdata,
    output int unsigned                                      pending,
    output int unsigned                                      failures
);

    localparam int VW = VALUE_WIDTH;
    localparam int CW = COUNT_WIDTH;

    typedef struct {
        logic [VW-1:0] value;
        logic          keep;
        logic          vend;
        logic [CW-1:0] dropped;
        logic [CW-1:0] seen;
    } masked_item_t;

    masked_item_t                     masked_q[$];

    logic                             train_on;
    logic [idm_pkg::THRESH_WIDTH-1:0] drop_thresh;
    logic [idm_pkg::SCALE_WIDTH-1:0]  gain;
    logic [idm_pkg::GEN_WIDTH-1:0]    gen;
    logic [CW-1:0]                    dropped_cnt;
    logic [CW-1:0]                    seen_cnt;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Multiply by the Q4.12 gain, floor toward minus infinity, saturate.
    function automatic logic [VW-1:0] apply_gain(input logic [VW-1:0] v);
        longint prod;
        longint q;
        longint hi;
        longint lo;
        hi   = (longint'(1) <<< (VW-1)) - 1;
        lo   = -hi - 1;
        prod = longint'($signed(v)) * longint'(gain);
        q    = prod >>> idm_pkg::SCALE_FRAC;
        if (q > hi)
            q = hi;
        if (q < lo)
            q = lo;
        return q[VW-1:0];
    endfunction

    function automatic masked_item_t predict_masked(input logic          op,
                                                    input logic [VW-1:0] v,
                                                    input logic          mask_bit,
                                                    input logic          last);
        masked_item_t r;
        r.value = v;
        r.keep  = 1'b0;
        r.vend  = last;
        if (op == idm_pkg::OP_FORWARD)
        begin
            r.keep = 1'b1;
            if (train_on)
            begin
                gen      = gen ^ (gen << idm_pkg::XS_SHIFT_A);
                gen      = gen ^ (gen >> idm_pkg::XS_SHIFT_B);
                gen      = gen ^ (gen << idm_pkg::XS_SHIFT_C);
                seen_cnt = sat_inc(seen_cnt);
                if (gen[idm_pkg::GEN_WIDTH-1 -: 16] < drop_thresh)
                begin
                    r.value     = '0;
                    r.keep      = 1'b0;
                    dropped_cnt = sat_inc(dropped_cnt);
                end
                else
                begin
                    r.value = apply_gain(v);
                end
            end
        end
        else if (train_on)
        begin
            r.value = mask_bit ? apply_gain(v) : '0;
        end
        r.dropped = dropped_cnt;
        r.seen    = seen_cnt;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            failures = failures + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        masked_item_t want;
        if (!rst_n)
        begin
            train_on    = 1'b1;
            drop_thresh = '0;
            gain        = idm_pkg::SCALE_RESET;
            gen         = idm_pkg::DEFAULT_SEED;
            dropped_cnt = '0;
            seen_cnt    = '0;
            failures    = 0;
            masked_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    idm_pkg::REG_TRAINING:  train_on    = cfg_wdata[0];
                    idm_pkg::REG_THRESHOLD: drop_thresh = cfg_wdata[idm_pkg::THRESH_WIDTH-1:0];
                    idm_pkg::REG_SCALE:     gain        = cfg_wdata[idm_pkg::SCALE_WIDTH-1:0];
                    idm_pkg::REG_SEED:
                        gen = (cfg_wdata != '0) ? cfg_wdata : idm_pkg::DEFAULT_SEED;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                masked_q.push_back(predict_masked(s_tuser, s_tdata[VW-1:0],
                                                  s_tdata[VW], s_tlast));
            if (m_tvalid && m_tready)
            begin
                if (masked_q.size() == 0)
                begin
                    $error("output transaction with no prediction waiting");
                    failures = failures + 1;
                end
                else
                begin
                    want = masked_q.pop_front();
                    check_field("value_out", 64'(want.value), 64'(m_tdata[VW-1:0]));
                    check_field("keep_flag", 64'(want.keep), 64'(m_tdata[VW]));
                    check_field("vector_end_out", 64'(want.vend), 64'(m_tlast));
                    check_field("dropped_total", 64'(want.dropped),
                                64'(m_tdata[VW+CW:VW+1]));
                    check_field("seen_total", 64'(want.seen),
                                64'(m_tdata[VW+2*CW:VW+CW+1]));
                end
            end
        end
        pending = masked_q.size();
    end

endmodule

### verif/inverted_dropout_masker_top_tb.sv
// ----------------------------------------------------------------------------
// inverted_dropout_masker_top_tb: stimulus and verdict for the dropout masker
// Directed extremes first, then random phases under varied register settings,
// with random idle bursts on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module inverted_dropout_masker_top_tb;

    localparam int VW              = idm_pkg::VALUE_WIDTH_DEFAULT;
    localparam int CW              = idm_pkg::COUNT_WIDTH_DEFAULT;
    localparam int SW              = ((VW+1+7)/8)*8;
    localparam int MW              = ((VW+1+2*CW+7)/8)*8;
    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 100;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 400000;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [SW-1:0]                       s_tdata   = '0;
    logic                                s_tuser   = 1'b0;
    logic                                s_tlast   = 1'b0;
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    logic [MW-1:0]                       m_tdata;
    logic                                m_tlast;
    logic                                cfg_wr_en = 1'b0;
    logic [idm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [idm_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata = '0;

    int unsigned pending;
    int unsigned failures;
    int unsigned cycles    = 0;
    bit          calm      = 1'b0;
    bit          hold_req  = 1'b0;
    bit          hold_done = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    inverted_dropout_masker_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    inverted_dropout_masker_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pending   (pending),
        .failures  (failures)
    );

    // Offer one element and hold it until the transaction completes.
    task automatic offer_element(input logic op, input logic [VW-1:0] v,
                                 input logic mask_bit, input logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(SW-VW-1){1'b0}}, mask_bit, v};
        s_tuser  <= op;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_settings(input logic train, input logic [15:0] thresh,
                                 input logic [15:0] scale, input logic [63:0] seed_val);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= idm_pkg::REG_TRAINING;
        cfg_wdata <= {63'd0, train};
        @(posedge clk);
        cfg_index <= idm_pkg::REG_THRESHOLD;
        cfg_wdata <= {48'd0, thresh};
        @(posedge clk);
        cfg_index <= idm_pkg::REG_SCALE;
        cfg_wdata <= {48'd0, scale};
        @(posedge clk);
        cfg_index <= idm_pkg::REG_SEED;
        cfg_wdata <= seed_val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [VW-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return {1'b1, {(VW-1){1'b0}}};
            1:       return {1'b0, {(VW-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return VW'($urandom);
        endcase
    endfunction

    // Output side: random ready bursts, one long hold-off, none when calm.
    initial
    begin
        wait (rst_n);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat (calm ? 1 : $urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles = cycles + 1;
        end
        $display("inverted_dropout_masker_top_tb NOT OK");
        $finish;
    end

    initial
    begin
        logic [15:0] thresh;
        logic [15:0] scale;
        logic [63:0] seed_val;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: training on, nothing dropped, unity gain.
        offer_element(idm_pkg::OP_FORWARD, 16'sh7FFF, 1'b0, 1'b0);
        offer_element(idm_pkg::OP_FORWARD, 16'sh8000, 1'b1, 1'b0);
        offer_element(idm_pkg::OP_FORWARD, 16'sh0000, 1'b0, 1'b0);
        offer_element(idm_pkg::OP_FORWARD, 16'shFFFF, 1'b0, 1'b1);
        offer_element(idm_pkg::OP_BACKWARD, 16'sh8000, 1'b1, 1'b0);
        offer_element(idm_pkg::OP_BACKWARD, 16'sh7FFF, 1'b0, 1'b1);

        // Heavy drop, top gain to saturate, zero seed picks the default.
        load_settings(1'b1, 16'hFFFF, 16'hFFFF, 64'd0);
        offer_element(idm_pkg::OP_FORWARD, 16'sh7FFF, 1'b0, 1'b0);
        offer_element(idm_pkg::OP_FORWARD, 16'sh8000, 1'b0, 1'b0);
        offer_element(idm_pkg::OP_FORWARD, 16'sh0001, 1'b1, 1'b0);
        offer_element(idm_pkg::OP_FORWARD, 16'shFFFF, 1'b1, 1'b1);
        offer_element(idm_pkg::OP_BACKWARD, 16'sh7FFF, 1'b1, 1'b0);
        offer_element(idm_pkg::OP_BACKWARD, 16'sh8000, 1'b1, 1'b0);
        offer_element(idm_pkg::OP_BACKWARD, 16'shFFFF, 1'b1, 1'b1);

        // Gain below one: kept values shrink, negatives floor downward.
        load_settings(1'b1, 16'h4000, 16'd3000, '1);
        offer_element(idm_pkg::OP_FORWARD, 16'sh8000, 1'b0, 1'b0);
        offer_element(idm_pkg::OP_FORWARD, 16'sh7FFF, 1'b0, 1'b0);
        offer_element(idm_pkg::OP_FORWARD, 16'shFFFD, 1'b0, 1'b0);
        offer_element(idm_pkg::OP_FORWARD, 16'sh0005, 1'b0, 1'b1);

        // Training off: everything passes through.
        load_settings(1'b0, 16'hFFFF, 16'hFFFF, 64'd12345);
        offer_element(idm_pkg::OP_FORWARD, 16'sh7FFF, 1'b0, 1'b0);
        offer_element(idm_pkg::OP_FORWARD, 16'sh8000, 1'b1, 1'b0);
        offer_element(idm_pkg::OP_BACKWARD, 16'sh8000, 1'b0, 1'b0);
        offer_element(idm_pkg::OP_BACKWARD, 16'sh04D2, 1'b1, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            case ($urandom_range(0, 4))
                0:       thresh = 16'h0000;
                1:       thresh = 16'hFFFF;
                2:       thresh = 16'h8000;
                default: thresh = 16'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0:       scale = idm_pkg::SCALE_RESET;
                1:       scale = 16'hFFFF;
                2:       scale = 16'($urandom_range(0, 4095));
                default: scale = 16'($urandom_range(4096, 65535));
            endcase
            case ($urandom_range(0, 3))
                0:       seed_val = 64'd0;
                1:       seed_val = '1;
                default: seed_val = {$urandom, $urandom};
            endcase
            load_settings($urandom_range(0, 4) != 0, thresh, scale, seed_val);
            calm     = (p == PHASES - 1);
            hold_req = (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
                offer_element(1'($urandom_range(0, 1)), pick_value(),
                              1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
        end

        wait_drained();
        if (failures == 0)
            $display("inverted_dropout_masker_top_tb OK");
        else
            $display("inverted_dropout_masker_top_tb NOT OK");
        $finish;
    end

endmodule
